[design/q8map_pkg.sv]
// Package for the 8-node quadrilateral natural-to-world mapping block.
// Holds the fixed field widths, fixed-point constants, shared types and the
// reset values of the reference points. No dependencies.
package q8map_pkg;

  localparam int NODES   = 8;
  localparam int IN_W    = 16;
  localparam int OUT_W   = 24;
  // Shape function magnitudes stay below 2^48 at scale 2^44.
  localparam int N44_W   = 49;
  // Weights after rounding from scale 2^44 down to Q30.
  localparam int WGT_W   = N44_W - 14;
  localparam int WGT_SH  = 14;
  localparam int SUM_SH  = 30;
  localparam int OUT_MAX = 8388607;
  localparam int OUT_MIN = -8388608;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;

  typedef logic signed [IN_W-1:0]  coord_in_t;
  typedef logic signed [OUT_W-1:0] pos_t;
  typedef logic signed [N44_W-1:0] n44_t;
  typedef logic signed [WGT_W-1:0] wgt_t;

  // Default square: node order corner, midside, corner, ... from (-1,-1).
  localparam logic [DATA_W-1:0] REF_RESET [NODES] = '{
    64'd2203284733440,
    64'd4261477888,
    64'd279280214932992,
    64'd279280214867968,
    64'd279280214868480,
    64'd4261413376,
    64'd2203284668928,
    64'd2203284668416
  };

endpackage

[design/q8map_regs.sv]
// Reference point register file behind the APB-style configuration port.
// Depends on q8map_pkg for the address and data widths and reset values.
module q8map_regs #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [q8map_pkg::ADDR_W-1:0]    paddr,
  input  logic [q8map_pkg::DATA_W-1:0]    pwdata,
  output logic [q8map_pkg::DATA_W-1:0]    prdata,
  output logic                            pready,
  output logic [3*COORD_WIDTH-1:0]        ref_pt_o [q8map_pkg::NODES]
);

  localparam int REG_W = 3 * COORD_WIDTH;

  logic [REG_W-1:0] ref_q [q8map_pkg::NODES];
  logic [REG_W-1:0] ref_d [q8map_pkg::NODES];
  logic             wr_en;
  logic [2:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[q8map_pkg::ADDR_W-1:3];

  always_comb begin
    ref_d = ref_q;
    if (wr_en) begin
      ref_d[reg_idx] = pwdata[REG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < q8map_pkg::NODES; i++) begin
        ref_q[i] <= REG_W'(q8map_pkg::REF_RESET[i]);
      end
    end else begin
      ref_q <= ref_d;
    end
  end

  assign prdata   = q8map_pkg::DATA_W'(ref_q[reg_idx]);
  assign ref_pt_o = ref_q;

endmodule

[design/q8map_shape.sv]
// Three-stage pipeline that evaluates the eight serendipity shape functions
// and rounds them to Q30 weights. Depends on q8map_pkg.
module q8map_shape (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  q8map_pkg::coord_in_t  xi_i,
  input  q8map_pkg::coord_in_t  eta_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output q8map_pkg::wgt_t       wgt_o [q8map_pkg::NODES]
);

  localparam logic signed [16:0] One17   = 17'sd16384;
  localparam logic signed [17:0] One18   = 18'sd16384;
  localparam logic signed [31:0] OneSq   = 32'sd268435456;
  localparam logic signed [q8map_pkg::N44_W-1:0] RndW =
    q8map_pkg::N44_W'(1) << (q8map_pkg::WGT_SH - 1);

  // Stage valid bits and per-stage ready chain.
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;

  assign rdy3       = !v3_q || !out_stall_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  // Stage 1: linear factors, corner pair products, corner sum terms and 1 - u^2 terms.
  logic signed [16:0] x17, e17, xm, xp, em, ep;
  logic signed [17:0] x18, e18;
  logic signed [31:0] xx, ee;
  logic signed [33:0] p_d [4];
  logic signed [17:0] t_d [4];
  logic signed [30:0] qx_d, qe_d;

  logic signed [33:0] p_q [4];
  logic signed [17:0] t_q [4];
  logic signed [30:0] qx_q, qe_q;
  logic signed [16:0] xm_q, xp_q, em_q, ep_q;

  assign x17 = {xi_i[15], xi_i};
  assign e17 = {eta_i[15], eta_i};
  assign x18 = {{2{xi_i[15]}}, xi_i};
  assign e18 = {{2{eta_i[15]}}, eta_i};
  assign xm  = One17 - x17;
  assign xp  = One17 + x17;
  assign em  = One17 - e17;
  assign ep  = One17 + e17;
  assign xx  = xi_i * xi_i;
  assign ee  = eta_i * eta_i;

  always_comb begin
    p_d[0] = xm * em;
    p_d[1] = xp * em;
    p_d[2] = xp * ep;
    p_d[3] = xm * ep;
    t_d[0] = -One18 - x18 - e18;
    t_d[1] = -One18 + x18 - e18;
    t_d[2] = -One18 + x18 + e18;
    t_d[3] = -One18 - x18 + e18;
    qx_d   = 31'(OneSq - xx);
    qe_d   = 31'(OneSq - ee);
  end

  // Stage 2: full shape function values at scale 2^44.
  q8map_pkg::n44_t    n_d [q8map_pkg::NODES];
  q8map_pkg::n44_t    n_q [q8map_pkg::NODES];
  logic signed [51:0] cp [4];
  logic signed [47:0] mx [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      cp[k] = p_q[k] * t_q[k];
    end
    mx[0] = qx_q * em_q;
    mx[1] = qe_q * xp_q;
    mx[2] = qx_q * ep_q;
    mx[3] = qe_q * xm_q;
    for (int k = 0; k < 4; k++) begin
      n_d[2*k]   = cp[k][q8map_pkg::N44_W-1:0];
      n_d[2*k+1] = {mx[k], 1'b0};
    end
  end

  // Stage 3: round half up to Q30; the upper part-select is a floor shift.
  q8map_pkg::wgt_t w_d [q8map_pkg::NODES];
  q8map_pkg::wgt_t w_q [q8map_pkg::NODES];

  always_comb begin
    logic signed [q8map_pkg::N44_W-1:0] rs;
    for (int i = 0; i < q8map_pkg::NODES; i++) begin
      rs     = n_q[i] + RndW;
      w_d[i] = rs[q8map_pkg::N44_W-1:q8map_pkg::WGT_SH];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      p_q  <= p_d;
      t_q  <= t_d;
      qx_q <= qx_d;
      qe_q <= qe_d;
      xm_q <= xm;
      xp_q <= xp;
      em_q <= em;
      ep_q <= ep;
    end
    if (rdy2 && v1_q) begin
      n_q <= n_d;
    end
    if (rdy3 && v2_q) begin
      w_q <= w_d;
    end
  end

  assign out_valid_o = v3_q;
  assign wgt_o       = w_q;

  // A held output stage keeps its weights; nodes 0 and 7 are checked.
  a_hold_weights: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && out_stall_i |=> v3_q && $stable(w_q[0]) && $stable(w_q[7]))
    else $error("held weight stage changed");

endmodule

[design/q8map_wsum.sv]
// Three-stage weighted sum of the reference points: products, partial sums,
// final sum with rounding and saturation. Depends on q8map_pkg.
module q8map_wsum #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  q8map_pkg::wgt_t           wgt_i [q8map_pkg::NODES],
  input  logic [3*COORD_WIDTH-1:0]  ref_pt_i [q8map_pkg::NODES],
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output q8map_pkg::pos_t           pos_x_o,
  output q8map_pkg::pos_t           pos_y_o,
  output q8map_pkg::pos_t           pos_z_o,
  output logic                      saturated_o
);

  localparam int PROD_W = q8map_pkg::WGT_W + COORD_WIDTH;
  localparam int SUM_W  = PROD_W + 4;
  localparam logic signed [SUM_W-1:0] SumRnd =
    {{(SUM_W - q8map_pkg::SUM_SH){1'b0}}, 1'b1, {(q8map_pkg::SUM_SH - 1){1'b0}}};
  localparam logic signed [SUM_W-1:0] SatHi = SUM_W'(q8map_pkg::OUT_MAX);
  localparam logic signed [SUM_W-1:0] SatLo = SUM_W'(q8map_pkg::OUT_MIN);

  logic v4_q, v5_q, v6_q;
  logic rdy4, rdy5, rdy6;

  assign rdy6       = !v6_q || !out_stall_i;
  assign rdy5       = !v5_q || rdy6;
  assign rdy4       = !v4_q || rdy5;
  assign in_stall_o = !rdy4;

  // Stage 4: one product per node and axis; axis 0 is x in the top field.
  logic signed [PROD_W-1:0] prod_d [3][q8map_pkg::NODES];
  logic signed [PROD_W-1:0] prod_q [3][q8map_pkg::NODES];

  always_comb begin
    logic signed [COORD_WIDTH-1:0] c;
    for (int a = 0; a < 3; a++) begin
      for (int i = 0; i < q8map_pkg::NODES; i++) begin
        c            = $signed(ref_pt_i[i][(2-a)*COORD_WIDTH +: COORD_WIDTH]);
        prod_d[a][i] = wgt_i[i] * c;
      end
    end
  end

  // Stage 5: two partial sums per axis; the rounding constant rides in the first.
  logic signed [SUM_W-1:0] half_d [3][2];
  logic signed [SUM_W-1:0] half_q [3][2];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      half_d[a][0] = prod_q[a][0] + prod_q[a][1] + prod_q[a][2] + prod_q[a][3] + SumRnd;
      half_d[a][1] = prod_q[a][4] + prod_q[a][5] + prod_q[a][6] + prod_q[a][7];
    end
  end

  // Stage 6: final sum, floor shift and clip to the output range.
  q8map_pkg::pos_t pos_d [3];
  q8map_pkg::pos_t pos_q [3];
  logic            sat_d, sat_q;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] r;
    sat_d = 1'b0;
    for (int a = 0; a < 3; a++) begin
      acc = half_q[a][0] + half_q[a][1];
      r   = acc >>> q8map_pkg::SUM_SH;
      if (r > SatHi) begin
        pos_d[a] = SatHi[q8map_pkg::OUT_W-1:0];
        sat_d    = 1'b1;
      end else if (r < SatLo) begin
        pos_d[a] = SatLo[q8map_pkg::OUT_W-1:0];
        sat_d    = 1'b1;
      end else begin
        pos_d[a] = r[q8map_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy4) begin
        v4_q <= in_valid_i;
      end
      if (rdy5) begin
        v5_q <= v4_q;
      end
      if (rdy6) begin
        v6_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && in_valid_i) begin
      prod_q <= prod_d;
    end
    if (rdy5 && v4_q) begin
      half_q <= half_d;
    end
    if (rdy6 && v5_q) begin
      pos_q <= pos_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = v6_q;
  assign pos_x_o     = pos_q[0];
  assign pos_y_o     = pos_q[1];
  assign pos_z_o     = pos_q[2];
  assign saturated_o = sat_q;

  // A clipped word always carries at least one coordinate at a range limit.
  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (pos_x_o == SatHi[q8map_pkg::OUT_W-1:0]) || (pos_x_o == SatLo[q8map_pkg::OUT_W-1:0]) ||
      (pos_y_o == SatHi[q8map_pkg::OUT_W-1:0]) || (pos_y_o == SatLo[q8map_pkg::OUT_W-1:0]) ||
      (pos_z_o == SatHi[q8map_pkg::OUT_W-1:0]) || (pos_z_o == SatLo[q8map_pkg::OUT_W-1:0]))
    else $error("saturation flag without a clipped coordinate");

endmodule

[design/quad8_natural_to_world_map.sv]
// Maps a natural coordinate pair (xi, eta) to a 3-D point with 8-node
// serendipity shape functions over eight configured reference points.
// An accepted word passes three shape stages, then three weighted-sum stages,
// to its result word. One word per cycle while out_stall_i is low. Reset
// clears all pipeline valid bits and loads the default square into the
// reference point registers.
module quad8_natural_to_world_map #(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [q8map_pkg::ADDR_W-1:0]  paddr,
  input  logic [q8map_pkg::DATA_W-1:0]  pwdata,
  output logic [q8map_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  q8map_pkg::coord_in_t          xi_coord_i,
  input  q8map_pkg::coord_in_t          eta_coord_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output q8map_pkg::pos_t               pos_x_o,
  output q8map_pkg::pos_t               pos_y_o,
  output q8map_pkg::pos_t               pos_z_o,
  output logic                          saturated_o
);

  logic [3*COORD_WIDTH-1:0] ref_pt [q8map_pkg::NODES];
  q8map_pkg::wgt_t          wgt [q8map_pkg::NODES];
  logic                     wgt_valid;
  logic                     wgt_stall;

  q8map_regs #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .ref_pt_o (ref_pt)
  );

  q8map_shape u_shape (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .xi_i        (xi_coord_i),
    .eta_i       (eta_coord_i),
    .out_valid_o (wgt_valid),
    .out_stall_i (wgt_stall),
    .wgt_o       (wgt)
  );

  q8map_wsum #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_wsum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (wgt_valid),
    .in_stall_o  (wgt_stall),
    .wgt_i       (wgt),
    .ref_pt_i    (ref_pt),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .saturated_o (saturated_o)
  );

  // Input stalls only when every stage is full and the result is not taken.
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && wgt_valid && wgt_stall)
    else $error("input stalled with a free pipeline slot");

  // The weight hand-off stalls only behind a blocked result word.
  a_mid_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wgt_stall |-> out_valid_o && out_stall_i)
    else $error("weight hand-off stalled while the result side can move");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for quad8_natural_to_world_map: random and directed
// (xi, eta) words with an in-house fixed-point predictor of the mapped point.
// Depends on q8map_pkg and the block's RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W   = 16;
  localparam int PT_STRIDE = 8;       // 48-bit registers sit on 8-byte addresses
  localparam int ONE_Q14   = 16384;
  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 300;

  typedef struct {
    q8map_pkg::coord_in_t xi;
    q8map_pkg::coord_in_t eta;
  } pair_t;

  typedef struct {
    q8map_pkg::pos_t px;
    q8map_pkg::pos_t py;
    q8map_pkg::pos_t pz;
    logic            sat;
  } point_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [q8map_pkg::ADDR_W-1:0]   paddr = '0;
  logic [q8map_pkg::DATA_W-1:0]   pwdata = '0;
  logic [q8map_pkg::DATA_W-1:0]   prdata;
  logic                           pready;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  q8map_pkg::coord_in_t           xi_coord_i = '0;
  q8map_pkg::coord_in_t           eta_coord_i = '0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  q8map_pkg::pos_t                pos_x_o;
  q8map_pkg::pos_t                pos_y_o;
  q8map_pkg::pos_t                pos_z_o;
  logic                           saturated_o;

  quad8_natural_to_world_map dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .xi_coord_i  (xi_coord_i),
    .eta_coord_i (eta_coord_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pos_x_o     (pos_x_o),
    .pos_y_o     (pos_y_o),
    .pos_z_o     (pos_z_o),
    .saturated_o (saturated_o)
  );

  logic [3*COORD_W-1:0] ref_pts [q8map_pkg::NODES];
  pair_t   pending_pairs [$];
  point_t  expected_pts [$];
  pair_t   next_pair;
  point_t  got_pt;
  point_t  want_pt;
  point_t  pred_pt;
  logic    in_took = 1'b0;
  logic    steady = 1'b0;
  logic    hold_req = 1'b0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      hold_left = 0;
  int      errors = 0;
  int      cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Round half toward plus infinity, then drop k fraction bits.
  function automatic longint round_q(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic point_t map_point(q8map_pkg::coord_in_t xi, q8map_pkg::coord_in_t eta);
    longint          x, e, s, xm, xp, em, ep, acc, r, c;
    longint          w [q8map_pkg::NODES];
    q8map_pkg::pos_t p [3];
    logic            sat;
    x = xi;
    e = eta;
    s = ONE_Q14;
    xm = s - x;
    xp = s + x;
    em = s - e;
    ep = s + e;
    w[0] = round_q(xm * em * (-s - x - e), q8map_pkg::WGT_SH);
    w[2] = round_q(xp * em * (-s + x - e), q8map_pkg::WGT_SH);
    w[4] = round_q(xp * ep * (-s + x + e), q8map_pkg::WGT_SH);
    w[6] = round_q(xm * ep * (-s - x + e), q8map_pkg::WGT_SH);
    w[1] = round_q(2 * ((s * s - x * x) * em), q8map_pkg::WGT_SH);
    w[5] = round_q(2 * ((s * s - x * x) * ep), q8map_pkg::WGT_SH);
    w[3] = round_q(2 * ((s * s - e * e) * xp), q8map_pkg::WGT_SH);
    w[7] = round_q(2 * ((s * s - e * e) * xm), q8map_pkg::WGT_SH);
    sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int i = 0; i < q8map_pkg::NODES; i++) begin
        c = $signed(ref_pts[i][(2 - a) * COORD_W +: COORD_W]);
        acc += w[i] * c;
      end
      r = round_q(acc, q8map_pkg::SUM_SH);
      if (r > q8map_pkg::OUT_MAX) begin
        r = q8map_pkg::OUT_MAX;
        sat = 1'b1;
      end
      if (r < q8map_pkg::OUT_MIN) begin
        r = q8map_pkg::OUT_MIN;
        sat = 1'b1;
      end
      p[a] = q8map_pkg::pos_t'(r);
    end
    return '{px: p[0], py: p[1], pz: p[2], sat: sat};
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic q8map_pkg::coord_in_t rand_coord(bit narrow);
    int r;
    r = $urandom_range(0, 99);
    if (narrow) return q8map_pkg::coord_in_t'(int'($urandom_range(0, 2048)) - 1024);
    if (r < 65) begin
      return q8map_pkg::coord_in_t'(int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14);
    end
    if (r < 75) begin
      unique case ($urandom_range(0, 4))
        0:       return q8map_pkg::coord_in_t'(-ONE_Q14);
        1:       return q8map_pkg::coord_in_t'(ONE_Q14);
        2:       return q8map_pkg::coord_in_t'(0);
        3:       return q8map_pkg::coord_in_t'(-32768);
        default: return q8map_pkg::coord_in_t'(32767);
      endcase
    end
    return q8map_pkg::coord_in_t'($urandom);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Driver: the next word goes out on the falling edge after a take or a gap.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_took) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        next_pair = pending_pairs.pop_front();
        xi_coord_i <= next_pair.xi;
        eta_coord_i <= next_pair.eta;
        in_valid_i <= 1'b1;
        if (!steady && $urandom_range(0, 99) < 35) gap_left = idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, including one long hold-off that lets the pipeline fill up.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_LEN;
      out_stall_i <= 1'b1;
    end else if (steady) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 20) begin
      stall_left = idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (in_took) begin
      pred_pt = map_point(xi_coord_i, eta_coord_i);
      expected_pts = {expected_pts, pred_pt};
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_pt = '{px: pos_x_o, py: pos_y_o, pz: pos_z_o, sat: saturated_o};
      if (expected_pts.size() == 0) begin
        $display("%0t: result word with nothing expected, got (%0d, %0d, %0d) sat %0b",
                 $time, pos_x_o, pos_y_o, pos_z_o, saturated_o);
        errors++;
      end else begin
        want_pt = expected_pts.pop_front();
        check_field("pos_x", want_pt.px, got_pt.px);
        check_field("pos_y", want_pt.py, got_pt.py);
        check_field("pos_z", want_pt.pz, got_pt.pz);
        check_field("saturated", want_pt.sat, got_pt.sat);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d words pending and %0d results outstanding",
               $time, pending_pairs.size(), expected_pts.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic write_point(input int node, input logic [q8map_pkg::DATA_W-1:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= q8map_pkg::ADDR_W'(node * PT_STRIDE);
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // Bits above the three packed coordinates are dropped by the block.
    ref_pts[node] = val[3*COORD_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic add_pair(input int xi, input int eta);
    pair_t item;
    item.xi = q8map_pkg::coord_in_t'(xi);
    item.eta = q8map_pkg::coord_in_t'(eta);
    pending_pairs = {pending_pairs, item};
  endtask

  task automatic push_directed();
    add_pair(-ONE_Q14, -ONE_Q14);
    add_pair(0, -ONE_Q14);
    add_pair(ONE_Q14, -ONE_Q14);
    add_pair(ONE_Q14, 0);
    add_pair(ONE_Q14, ONE_Q14);
    add_pair(0, ONE_Q14);
    add_pair(-ONE_Q14, ONE_Q14);
    add_pair(-ONE_Q14, 0);
    add_pair(0, 0);
    add_pair(8192, 8192);
    add_pair(-8192, 12288);
    add_pair(-32768, -32768);
    add_pair(32767, 32767);
    add_pair(-32768, 32767);
    add_pair(32767, -32768);
    add_pair(-32768, 0);
    add_pair(0, 32767);
    add_pair(16'h5555, 16'hAAAA);
    add_pair(16'hAAAA, 16'h5555);
    add_pair(1, -1);
  endtask

  task automatic push_random(input int n, input bit narrow);
    for (int k = 0; k < n; k++) add_pair(rand_coord(narrow), rand_coord(narrow));
  endtask

  // Sender pause: nothing more is offered until every result has come back.
  task automatic drain();
    while (pending_pairs.size() != 0 || in_valid_i || expected_pts.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    for (int i = 0; i < q8map_pkg::NODES; i++) begin
      ref_pts[i] = q8map_pkg::REF_RESET[i][3*COORD_W-1:0];
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default square from reset.
    push_directed();
    push_random(120, 1'b0);
    drain();

    // Random points with junk in the unused upper bits, plus the long hold-off.
    for (int i = 0; i < q8map_pkg::NODES; i++) write_point(i, {$urandom, $urandom});
    push_random(160, 1'b0);
    hold_req = 1'b1;
    drain();

    // Most positive and most negative coordinates on alternating nodes.
    for (int i = 0; i < q8map_pkg::NODES; i++)
      write_point(i, {16'($urandom), (i % 2 == 0) ? 48'h7FFF_7FFF_7FFF : 48'h8000_8000_8000});
    push_directed();
    push_random(80, 1'b0);
    drain();

    // All-max points.
    for (int i = 0; i < q8map_pkg::NODES; i++) write_point(i, 64'h0000_7FFF_7FFF_7FFF);
    push_random(40, 1'b0);
    drain();

    // All-zero points with no idling on either side.
    for (int i = 0; i < q8map_pkg::NODES; i++) write_point(i, '0);
    steady = 1'b1;
    push_random(60, 1'b0);
    drain();
    steady = 1'b0;

    // Random points again, coordinates clustered near the center.
    for (int i = 0; i < q8map_pkg::NODES; i++) write_point(i, {$urandom, $urandom});
    push_random(120, 1'b1);
    drain();

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
